### rtl/core/cdeq_pkg.sv
package cdeq_pkg;

  // Fixed widths of the stream fields.
  localparam int ENTRY_W  = 64;
  localparam int POP_W    = 7;
  localparam int OCC_W    = 11;
  localparam int CFG_W    = 11;
  localparam int CMD_W    = 3;
  localparam int STATUS_W = 2;

  // s_tdata: entry_in, pop_count, one pad bit. m_tdata: entry_out, occupancy,
  // is_empty, is_full, three pad bits.
  localparam int S_TDATA_W = 72;
  localparam int S_TUSER_W = CMD_W;
  localparam int M_TDATA_W = 80;
  localparam int M_TUSER_W = STATUS_W;

  localparam int MAX_SLOTS_DEF   = 1024;
  localparam int ENTRY_BITS_DEF  = 64;
  localparam int MAX_POP_RUN_DEF = 64;
  localparam int CMDQ_DEPTH      = 2;

  localparam logic [CMD_W-1:0] OP_PUSH_BACK  = 3'd0;
  localparam logic [CMD_W-1:0] OP_PUSH_FRONT = 3'd1;
  localparam logic [CMD_W-1:0] OP_POP_BACK   = 3'd2;
  localparam logic [CMD_W-1:0] OP_POP_FRONT  = 3'd3;
  localparam logic [CMD_W-1:0] OP_PEEK_BACK  = 3'd4;
  localparam logic [CMD_W-1:0] OP_PEEK_FRONT = 3'd5;
  localparam logic [CMD_W-1:0] OP_CLEAR      = 3'd6;
  localparam logic [CMD_W-1:0] OP_POP_MANY   = 3'd7;

  localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd2;

  typedef struct packed {
    logic [CMD_W-1:0]   op;
    logic [POP_W-1:0]   count;
    logic [ENTRY_W-1:0] data;
  } cmd_t;

endpackage

### rtl/core/cdeq_ram.sv
module cdeq_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### rtl/core/cdeq_cmdq.sv
module cdeq_cmdq (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  cdeq_pkg::cmd_t  in_cmd,
  output logic            out_valid,
  input  logic            out_ready,
  output cdeq_pkg::cmd_t  out_cmd
);

  import cdeq_pkg::*;

  localparam int PW = $clog2(CMDQ_DEPTH);

  cmd_t          mem [CMDQ_DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [PW:0]   fill;
  logic          push;
  logic          pop;

  assign in_ready  = fill != (PW+1)'(CMDQ_DEPTH);
  assign out_valid = fill != '0;
  assign out_cmd   = mem[rd_ptr];
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= in_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + PW'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + PW'(1);
      end
      if (push && !pop) begin
        fill <= fill + (PW+1)'(1);
      end else if (pop && !push) begin
        fill <= fill - (PW+1)'(1);
      end
    end
  end

endmodule

### rtl/core/cdeq_front.sv
module cdeq_front #(
  parameter int ENTRY_BITS  = 64,
  parameter int MAX_POP_RUN = 64
) (
  input  logic                             s_tvalid,
  output logic                             s_tready,
  input  logic [cdeq_pkg::S_TDATA_W-1:0]   s_tdata,  // entry_in, pop_count
  input  logic [cdeq_pkg::S_TUSER_W-1:0]   s_tuser,  // cmd
  output logic                             q_valid,
  input  logic                             q_ready,
  output cdeq_pkg::cmd_t                   q_cmd
);

  import cdeq_pkg::*;

  localparam logic [ENTRY_W-1:0] ENTRY_MASK =
    ENTRY_W'((65'd1 << ENTRY_BITS) - 65'd1);

  logic [ENTRY_W-1:0] entry_in;
  logic [POP_W-1:0]   pop_count;

  assign entry_in  = s_tdata[ENTRY_W-1:0];
  assign pop_count = s_tdata[ENTRY_W +: POP_W];

  // Payload is trimmed to the stored width and the run length is clamped here,
  // so the back end sees only values it can execute directly.
  always_comb begin
    q_cmd.op   = s_tuser;
    q_cmd.data = entry_in & ENTRY_MASK;
    if (32'(pop_count) > MAX_POP_RUN) begin
      q_cmd.count = POP_W'(MAX_POP_RUN);
    end else begin
      q_cmd.count = pop_count;
    end
  end

  assign q_valid  = s_tvalid;
  assign s_tready = q_ready;

endmodule

### rtl/core/cdeq_back.sv
module cdeq_back #(
  parameter int MAX_SLOTS  = 1024,
  parameter int ENTRY_BITS = 64
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_wr,
  input  logic [cdeq_pkg::CFG_W-1:0]     cfg_value,
  input  logic                           cmd_valid,
  output logic                           cmd_ready,
  input  cdeq_pkg::cmd_t                 cmd,
  output logic                           m_tvalid,
  input  logic                           m_tready,
  output logic [cdeq_pkg::M_TDATA_W-1:0] m_tdata,  // entry_out, occupancy, is_empty, is_full
  output logic [cdeq_pkg::M_TUSER_W-1:0] m_tuser,  // status
  output logic                           m_tlast
);

  import cdeq_pkg::*;

  localparam int AW = $clog2(MAX_SLOTS);
  localparam int CW = $clog2(MAX_SLOTS + 1);

  localparam logic [1:0] BK_IDLE = 2'd0;
  localparam logic [1:0] BK_WAIT = 2'd1;
  localparam logic [1:0] BK_MANY = 2'd2;

  logic [1:0]       state, state_next;
  logic [AW-1:0]    front_gap, front_gap_next;
  logic [AW-1:0]    rear_gap, rear_gap_next;
  logic [CW-1:0]    entry_count, entry_count_next;
  logic [CW-1:0]    cap, cap_next;
  logic [POP_W-1:0] remaining, remaining_next;
  logic             last_pend, last_pend_next;

  logic                  out_valid;
  logic [STATUS_W-1:0]   out_status;
  logic [ENTRY_W-1:0]    out_entry;
  logic                  out_last;
  logic [OCC_W-1:0]      out_occ;
  logic                  out_empty;
  logic                  out_full;

  logic                  load_out;
  logic [STATUS_W-1:0]   ld_status;
  logic [ENTRY_W-1:0]    ld_entry;
  logic                  ld_last;
  logic                  out_free;

  logic                  ram_we;
  logic [AW-1:0]         ram_waddr;
  logic [ENTRY_BITS-1:0] ram_wdata;
  logic [AW-1:0]         ram_raddr;
  logic [ENTRY_BITS-1:0] ram_rdata;

  logic          is_full_now;
  logic          is_empty_now;
  logic [AW-1:0] rear_dec, rear_inc, front_dec, front_inc;
  logic [CW-1:0] cfg_cap;

  cdeq_ram #(
    .WIDTH (ENTRY_BITS),
    .DEPTH (MAX_SLOTS)
  ) u_slots (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign out_free     = !out_valid || m_tready;
  assign is_full_now  = entry_count >= cap;
  assign is_empty_now = entry_count == '0;

  assign rear_inc  = (CW'(rear_gap) + CW'(1) >= cap) ? '0 : rear_gap + AW'(1);
  assign front_inc = (CW'(front_gap) + CW'(1) >= cap) ? '0 : front_gap + AW'(1);
  assign rear_dec  = (rear_gap == '0) ? AW'(cap - CW'(1)) : rear_gap - AW'(1);
  assign front_dec = (front_gap == '0) ? AW'(cap - CW'(1)) : front_gap - AW'(1);

  always_comb begin
    if (cfg_value < CFG_W'(2)) begin
      cfg_cap = CW'(2);
    end else if (32'(cfg_value) > MAX_SLOTS) begin
      cfg_cap = CW'(MAX_SLOTS);
    end else begin
      cfg_cap = CW'(cfg_value);
    end
  end

  always_comb begin
    state_next       = state;
    front_gap_next   = front_gap;
    rear_gap_next    = rear_gap;
    entry_count_next = entry_count;
    cap_next         = cap;
    remaining_next   = remaining;
    last_pend_next   = last_pend;
    cmd_ready        = 1'b0;
    ram_we           = 1'b0;
    ram_waddr        = rear_gap;
    ram_wdata        = cmd.data[ENTRY_BITS-1:0];
    ram_raddr        = rear_dec;
    load_out         = 1'b0;
    ld_status        = STATUS_OK;
    ld_entry         = '0;
    ld_last          = 1'b1;

    case (state)
      BK_IDLE: begin
        if (cmd_valid && out_free) begin
          cmd_ready = 1'b1;
          case (cmd.op)
            OP_PUSH_BACK, OP_PUSH_FRONT: begin
              load_out = 1'b1;
              if (is_full_now) begin
                ld_status = STATUS_FULL;
              end else begin
                ram_we           = 1'b1;
                entry_count_next = entry_count + CW'(1);
                if (cmd.op == OP_PUSH_BACK) begin
                  ram_waddr     = rear_gap;
                  rear_gap_next = rear_inc;
                end else begin
                  ram_waddr      = front_gap;
                  front_gap_next = front_dec;
                end
              end
            end
            OP_POP_BACK, OP_POP_FRONT, OP_PEEK_BACK, OP_PEEK_FRONT: begin
              if (is_empty_now) begin
                load_out  = 1'b1;
                ld_status = STATUS_EMPTY;
              end else begin
                // The slot comes back from the memory next cycle.
                last_pend_next = 1'b1;
                state_next     = BK_WAIT;
                if (cmd.op == OP_POP_BACK || cmd.op == OP_PEEK_BACK) begin
                  ram_raddr = rear_dec;
                end else begin
                  ram_raddr = front_inc;
                end
                if (cmd.op == OP_POP_BACK) begin
                  rear_gap_next    = rear_dec;
                  entry_count_next = entry_count - CW'(1);
                end else if (cmd.op == OP_POP_FRONT) begin
                  front_gap_next   = front_inc;
                  entry_count_next = entry_count - CW'(1);
                end
              end
            end
            OP_CLEAR: begin
              load_out         = 1'b1;
              front_gap_next   = '0;
              rear_gap_next    = AW'(1);
              entry_count_next = '0;
            end
            default: begin
              if (cmd.count == '0) begin
                load_out = 1'b1;
              end else begin
                remaining_next = cmd.count;
                state_next     = BK_MANY;
              end
            end
          endcase
        end
      end
      BK_WAIT: begin
        // The output register is always free here: the read was issued
        // only when it was free, and nothing was loaded in that cycle.
        load_out   = 1'b1;
        ld_entry   = ENTRY_W'(ram_rdata);
        ld_last    = last_pend;
        state_next = last_pend ? BK_IDLE : BK_MANY;
      end
      BK_MANY: begin
        if (out_free) begin
          if (is_empty_now) begin
            load_out   = 1'b1;
            ld_status  = STATUS_EMPTY;
            state_next = BK_IDLE;
          end else begin
            ram_raddr        = rear_dec;
            rear_gap_next    = rear_dec;
            entry_count_next = entry_count - CW'(1);
            remaining_next   = remaining - POP_W'(1);
            last_pend_next   = remaining == POP_W'(1);
            state_next       = BK_WAIT;
          end
        end
      end
      default: begin
        state_next = BK_IDLE;
      end
    endcase

    // A capacity write always empties the ring.
    if (cfg_wr) begin
      cap_next         = cfg_cap;
      front_gap_next   = '0;
      rear_gap_next    = AW'(1);
      entry_count_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= BK_IDLE;
      front_gap   <= '0;
      rear_gap    <= AW'(1);
      entry_count <= '0;
      cap         <= CW'(MAX_SLOTS);
      remaining   <= '0;
      last_pend   <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      state       <= state_next;
      front_gap   <= front_gap_next;
      rear_gap    <= rear_gap_next;
      entry_count <= entry_count_next;
      cap         <= cap_next;
      remaining   <= remaining_next;
      last_pend   <= last_pend_next;
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_status <= ld_status;
      out_entry  <= ld_entry;
      out_last   <= ld_last;
      out_occ    <= OCC_W'(entry_count_next);
      out_empty  <= entry_count_next == '0;
      out_full   <= entry_count_next == cap;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tuser  = out_status;
  assign m_tlast  = out_last;
  assign m_tdata  = {3'b000, out_full, out_empty, out_occ, out_entry};

  assert property (@(posedge clk) disable iff (rst) entry_count <= cap)
    else $error("entry count exceeds the ring capacity");

  assert property (@(posedge clk) disable iff (rst)
    (CW'(rear_gap) < cap) && (CW'(front_gap) < cap))
    else $error("ring pointer outside the ring");

  assert property (@(posedge clk) disable iff (rst) state == BK_WAIT |-> !out_valid)
    else $error("read data returned while the output register is occupied");

  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_last |-> state == BK_MANY || state == BK_WAIT)
    else $error("non-final result outside a multi-pop run");

endmodule

### rtl/core/circular_double_ended_queue.sv
// A push, clear or refused command shows its result after passing the command queue and the
// output register; a pop or peek also passes the slot memory, whose read is registered.
// Pushes and clears 1 per cycle while the output is not stalled; a pop or peek holds the back
// end in a wait state until its slot read returns, taking no other command; a multi-pop run
// reads and removes one entry at a time, and gives an empty status when the ring runs out.
// Reset (rst, synchronous): empties the ring and sets the capacity to MAX_SLOTS.
// Slot contents are not cleared and no clearing pass runs after reset.
module circular_double_ended_queue #(
  parameter int MAX_SLOTS   = cdeq_pkg::MAX_SLOTS_DEF,
  parameter int ENTRY_BITS  = cdeq_pkg::ENTRY_BITS_DEF,
  parameter int MAX_POP_RUN = cdeq_pkg::MAX_POP_RUN_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [cdeq_pkg::CFG_W-1:0]     cfg_data,  // capacity_in_use
  input  logic                           s_tvalid,
  output logic                           s_tready,
  input  logic [cdeq_pkg::S_TDATA_W-1:0] s_tdata,   // entry_in, pop_count
  input  logic [cdeq_pkg::S_TUSER_W-1:0] s_tuser,   // cmd
  output logic                           m_tvalid,
  input  logic                           m_tready,
  output logic [cdeq_pkg::M_TDATA_W-1:0] m_tdata,   // entry_out, occupancy, is_empty, is_full
  output logic [cdeq_pkg::M_TUSER_W-1:0] m_tuser,   // status
  output logic                           m_tlast
);

  import cdeq_pkg::*;

  logic fr_valid;
  logic fr_ready;
  cmd_t fr_cmd;
  logic bk_valid;
  logic bk_ready;
  cmd_t bk_cmd;

  assign cfg_ready = 1'b1;

  cdeq_front #(
    .ENTRY_BITS  (ENTRY_BITS),
    .MAX_POP_RUN (MAX_POP_RUN)
  ) u_front (
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .q_valid  (fr_valid),
    .q_ready  (fr_ready),
    .q_cmd    (fr_cmd)
  );

  cdeq_cmdq u_cmdq (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (fr_valid),
    .in_ready  (fr_ready),
    .in_cmd    (fr_cmd),
    .out_valid (bk_valid),
    .out_ready (bk_ready),
    .out_cmd   (bk_cmd)
  );

  cdeq_back #(
    .MAX_SLOTS  (MAX_SLOTS),
    .ENTRY_BITS (ENTRY_BITS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr    (cfg_valid && cfg_ready),
    .cfg_value (cfg_data),
    .cmd_valid (bk_valid),
    .cmd_ready (bk_ready),
    .cmd       (bk_cmd),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast)
  );

endmodule

### sim/tb.sv
`timescale 1ns / 100ps

module tb;
  import cdeq_pkg::*;

  localparam int CYCLE_LIMIT      = 2000000;
  localparam int LONG_HOLD_CYCLES = 150;
  localparam int SETTLE_CYCLES    = 8;
  localparam int PHASE_ITEMS      = 46;

  typedef struct {
    logic [STATUS_W-1:0] status;
    logic [ENTRY_W-1:0]  entry;
    logic                last;
    logic [OCC_W-1:0]    occupancy;
    logic                is_empty;
    logic                is_full;
  } deque_result_t;

  class deque_scoreboard;
    logic [ENTRY_W-1:0] ring [MAX_SLOTS_DEF];
    int unsigned head_gap;
    int unsigned tail_gap;
    int unsigned held;
    int unsigned cap_raw;
    int unsigned errors;
    deque_result_t pending_results [$];

    function new();
      cap_raw = MAX_SLOTS_DEF;
      errors  = 0;
      clear_ring();
    endfunction

    function void clear_ring();
      head_gap = 0;
      tail_gap = 1;
      held     = 0;
    endfunction

    // Out-of-range capacities are clamped into the ring.
    function int unsigned ring_size();
      if (cap_raw < 2) return 2;
      if (cap_raw > MAX_SLOTS_DEF) return MAX_SLOTS_DEF;
      return cap_raw;
    endfunction

    function int unsigned step_up(int unsigned i);
      return (i + 1 >= ring_size()) ? 0 : i + 1;
    endfunction

    function int unsigned step_down(int unsigned i);
      return (i == 0 || i > ring_size()) ? ring_size() - 1 : i - 1;
    endfunction

    function void set_capacity(logic [CFG_W-1:0] value);
      cap_raw = value;
      clear_ring();
    endfunction

    function void add_result(logic [STATUS_W-1:0] status, logic [ENTRY_W-1:0] entry,
                             logic last);
      deque_result_t r;
      r.status    = status;
      r.entry     = entry;
      r.last      = last;
      r.occupancy = OCC_W'(held);
      r.is_empty  = (held == 0);
      r.is_full   = (held == ring_size());
      pending_results.insert(pending_results.size(), r);
    endfunction

    function void predict_command(logic [CMD_W-1:0] op, logic [ENTRY_W-1:0] data,
                                  logic [POP_W-1:0] count);
      bit full;
      bit empty;
      int unsigned run;
      full  = held >= ring_size();
      empty = held == 0;
      case (op)
        OP_PUSH_BACK, OP_PUSH_FRONT: begin
          if (full) begin
            add_result(STATUS_FULL, '0, 1'b1);
          end else if (op == OP_PUSH_BACK) begin
            ring[tail_gap] = data;
            held++;
            tail_gap = step_up(tail_gap);
            add_result(STATUS_OK, '0, 1'b1);
          end else begin
            ring[head_gap] = data;
            held++;
            head_gap = step_down(head_gap);
            add_result(STATUS_OK, '0, 1'b1);
          end
        end
        OP_POP_BACK, OP_POP_FRONT, OP_PEEK_BACK, OP_PEEK_FRONT: begin
          if (empty) begin
            add_result(STATUS_EMPTY, '0, 1'b1);
          end else if (op == OP_POP_BACK) begin
            tail_gap = step_down(tail_gap);
            held--;
            add_result(STATUS_OK, ring[tail_gap], 1'b1);
          end else if (op == OP_POP_FRONT) begin
            head_gap = step_up(head_gap);
            held--;
            add_result(STATUS_OK, ring[head_gap], 1'b1);
          end else if (op == OP_PEEK_BACK) begin
            add_result(STATUS_OK, ring[step_down(tail_gap)], 1'b1);
          end else begin
            add_result(STATUS_OK, ring[step_up(head_gap)], 1'b1);
          end
        end
        OP_CLEAR: begin
          clear_ring();
          add_result(STATUS_OK, '0, 1'b1);
        end
        default: begin
          run = (count > MAX_POP_RUN_DEF) ? MAX_POP_RUN_DEF : count;
          if (run == 0) begin
            add_result(STATUS_OK, '0, 1'b1);
          end else begin
            for (int i = 0; i < run; i++) begin
              if (held == 0) begin
                add_result(STATUS_EMPTY, '0, 1'b1);
                break;
              end
              tail_gap = step_down(tail_gap);
              held--;
              add_result(STATUS_OK, ring[tail_gap], (i + 1 == run));
            end
          end
        end
      endcase
    endfunction

    task report(string msg);
      $display("MISMATCH: %s", msg);
      errors++;
    endtask

    task check_result(deque_result_t got);
      deque_result_t want;
      string bad;
      bad = "";
      if (pending_results.size() == 0) begin
        report($sformatf("result with nothing pending: %p", got));
        return;
      end
      want = pending_results[0];
      pending_results.delete(0);
      if (got.status !== want.status) bad = {bad, " status"};
      if (got.entry !== want.entry) bad = {bad, " entry_out"};
      if (got.last !== want.last) bad = {bad, " last"};
      if (got.occupancy !== want.occupancy) bad = {bad, " occupancy"};
      if (got.is_empty !== want.is_empty) bad = {bad, " is_empty"};
      if (got.is_full !== want.is_full) bad = {bad, " is_full"};
      if (bad != "") report($sformatf("wrong%s: got %p want %p", bad, got, want));
    endtask
  endclass

  logic                 clk;
  logic                 rst       = 1'b1;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_W-1:0]     cfg_data  = '0;
  logic                 s_tvalid  = 1'b0;
  logic                 s_tready;
  logic [S_TDATA_W-1:0] s_tdata   = '0;  // entry_in, pop_count, pad
  logic [S_TUSER_W-1:0] s_tuser   = '0;  // cmd
  logic                 m_tvalid;
  logic                 m_tready  = 1'b0;
  logic [M_TDATA_W-1:0] m_tdata;         // entry_out, occupancy, is_empty, is_full, pad
  logic [M_TUSER_W-1:0] m_tuser;         // status
  logic                 m_tlast;

  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned cycle_count    = 0;
  logic        receiver_held  = 1'b0;
  event        long_hold_start;

  deque_scoreboard scoreboard = new();

  circular_double_ended_queue u_top (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    if (receiver_held) begin
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  initial forever begin
    @(long_hold_start);
    receiver_held <= 1'b1;
    repeat (LONG_HOLD_CYCLES) @(posedge clk);
    receiver_held <= 1'b0;
  end

  // Transfers are observed on the values present at the edge.
  always @(posedge clk) begin
    if (!rst && cfg_valid && cfg_ready) scoreboard.set_capacity(cfg_data);
    if (!rst && s_tvalid && s_tready) begin
      scoreboard.predict_command(s_tuser, s_tdata[ENTRY_W-1:0],
                                 s_tdata[ENTRY_W+POP_W-1:ENTRY_W]);
    end
  end

  always @(posedge clk) begin
    deque_result_t got;
    if (!rst && m_tvalid && m_tready) begin
      got.status    = m_tuser;
      got.entry     = m_tdata[ENTRY_W-1:0];
      got.last      = m_tlast;
      got.occupancy = m_tdata[ENTRY_W+OCC_W-1:ENTRY_W];
      got.is_empty  = m_tdata[ENTRY_W+OCC_W];
      got.is_full   = m_tdata[ENTRY_W+OCC_W+1];
      scoreboard.check_result(got);
    end
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Test completed with failures");
    $finish;
  end

  task automatic send_command(input logic [CMD_W-1:0] op, input logic [ENTRY_W-1:0] data,
                              input logic [POP_W-1:0] count);
    if ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {1'b0, count, data};
    s_tuser  <= op;
    do @(posedge clk); while (!s_tready);
  endtask

  task automatic wait_drained();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (scoreboard.pending_results.size() != 0);
  endtask

  task automatic write_capacity(input logic [CFG_W-1:0] value);
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  // Mostly pushes and short pops so the ring fills and wraps; long pop runs are rare.
  function automatic void pick_command(output logic [CMD_W-1:0] op,
                                       output logic [ENTRY_W-1:0] data,
                                       output logic [POP_W-1:0] count);
    int unsigned r;
    r     = $urandom_range(99);
    data  = {$urandom, $urandom};
    count = ($urandom_range(19) == 0) ? POP_W'($urandom_range(127))
                                      : POP_W'($urandom_range(5));
    if (r < 28) op = OP_PUSH_BACK;
    else if (r < 56) op = OP_PUSH_FRONT;
    else if (r < 64) op = OP_POP_BACK;
    else if (r < 72) op = OP_POP_FRONT;
    else if (r < 80) op = OP_PEEK_BACK;
    else if (r < 90) op = OP_PEEK_FRONT;
    else if (r < 92) op = OP_CLEAR;
    else op = OP_POP_MANY;
  endfunction

  initial begin
    logic [CMD_W-1:0]   op;
    logic [ENTRY_W-1:0] data;
    logic [POP_W-1:0]   count;
    logic [CFG_W-1:0]   cap;

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Empty ring at the reset capacity: every pop and peek is refused; a zero-length run returns OK.
    send_command(OP_POP_BACK, '1, 7'd0);
    send_command(OP_POP_FRONT, '1, 7'd0);
    send_command(OP_PEEK_BACK, '0, 7'd0);
    send_command(OP_PEEK_FRONT, '0, 7'd0);
    send_command(OP_POP_MANY, '0, 7'd3);
    send_command(OP_POP_MANY, '0, 7'd0);
    send_command(OP_PUSH_BACK, '0, 7'd127);
    send_command(OP_PUSH_BACK, '1, 7'd0);
    send_command(OP_PUSH_FRONT, 64'h5555_5555_5555_5555, 7'd0);
    send_command(OP_PUSH_FRONT, 64'hAAAA_AAAA_AAAA_AAAA, 7'd0);
    send_command(OP_PEEK_BACK, '0, 7'd0);
    send_command(OP_PEEK_FRONT, '0, 7'd0);
    send_command(OP_POP_FRONT, '0, 7'd0);
    send_command(OP_POP_BACK, '0, 7'd0);
    send_command(OP_POP_MANY, '0, 7'd0);
    // A count above the run limit is clamped and the run stops when empty.
    send_command(OP_POP_MANY, '0, 7'd127);
    send_command(OP_PUSH_BACK, 64'h0123_4567_89AB_CDEF, 7'd0);
    send_command(OP_CLEAR, '0, 7'd0);
    send_command(OP_PEEK_FRONT, '0, 7'd0);

    // A capacity of zero behaves as the two-slot minimum.
    write_capacity(11'd0);
    send_command(OP_PUSH_FRONT, 64'hFEED_0000_0000_0001, 7'd0);
    send_command(OP_PUSH_BACK, 64'hFEED_0000_0000_0002, 7'd0);
    send_command(OP_PUSH_BACK, 64'hFEED_0000_0000_0003, 7'd0);
    send_command(OP_POP_MANY, '0, 7'd2);
    send_command(OP_PUSH_FRONT, 64'hFEED_0000_0000_0004, 7'd0);
    send_command(OP_PUSH_FRONT, 64'hFEED_0000_0000_0005, 7'd0);
    send_command(OP_PUSH_FRONT, 64'hFEED_0000_0000_0006, 7'd0);

    // Writing the capacity empties a full ring; too large a value acts as the maximum.
    write_capacity(11'd2047);
    send_command(OP_POP_BACK, '0, 7'd0);
    send_command(OP_PUSH_BACK, 64'h8000_0000_0000_0001, 7'd0);
    send_command(OP_POP_MANY, '0, 7'd64);

    for (int p = 0; p < 8; p++) begin
      case (p)
        0: cap = 11'd5;
        1: cap = 11'd2;
        2: cap = 11'd48;
        3: cap = 11'd1024;
        4: cap = 11'd1;
        5: cap = 11'd2047;
        6: cap = 11'd13;
        default: cap = 11'd3;
      endcase
      write_capacity(cap);
      case (p % 4)
        0: begin
          send_idle_pct  = 0;
          recv_stall_pct = 0;
        end
        1: begin
          send_idle_pct  = 87;
          recv_stall_pct = 0;
        end
        2: begin
          send_idle_pct  = 0;
          recv_stall_pct = 87;
        end
        default: begin
          send_idle_pct  = 34;
          recv_stall_pct = 34;
        end
      endcase
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        // Back-pressure long enough to fill the block and stall its input.
        if (p == 0 && i == 12) -> long_hold_start;
        if (p == 0 && i == 34) wait_drained();
        pick_command(op, data, count);
        send_command(op, data, count);
      end
    end

    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (scoreboard.errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
